// ===== design/gcy_pkg.sv =====
// Shared constants, types and loop state codes for the gyro conditioning block.
// Used by every module under design/; depends on nothing else.

package gcy_pkg;

    // Field widths
    localparam int RATE_W    = 16;
    localparam int NUM_AXES  = 3;
    localparam int PITCH_W   = 32;
    localparam int YAW_W     = 21;
    localparam int LIM_W     = 20;
    localparam int STATE_W   = 4;
    localparam int CFG_IDX_W = 1;

    // Moving average history
    localparam int HIST_DEPTH = 10;
    localparam int HSUM_W     = RATE_W + $clog2(HIST_DEPTH);

    // Division of the history sum by HIST_DEPTH as a multiply by a rounded-up reciprocal.
    localparam int AVG_SHIFT = HSUM_W + $clog2(HIST_DEPTH);
    localparam int AVG_MUL_W = HSUM_W + 2;
    localparam int AVG_PROD_W = HSUM_W + AVG_MUL_W;
    localparam logic [AVG_MUL_W-1:0] AVG_MUL =
        AVG_MUL_W'(((64'd1 << AVG_SHIFT) + 64'(HIST_DEPTH) - 64'd1) / 64'(HIST_DEPTH));

    // Bias calibration
    localparam int CALIB_TICKS = 200;
    localparam int CNT_W       = 8;
    localparam int CSUM_W      = 32;

    // Division of a calibration sum magnitude by CALIB_TICKS, same reciprocal scheme.
    localparam int CAL_SHIFT  = CSUM_W + $clog2(CALIB_TICKS);
    localparam int CAL_MUL_W  = CSUM_W + 2;
    localparam int CAL_PROD_W = CSUM_W + CAL_MUL_W;
    localparam logic [CAL_MUL_W-1:0] CAL_MUL =
        CAL_MUL_W'(((64'd1 << CAL_SHIFT) + 64'(CALIB_TICKS) - 64'd1) / 64'(CALIB_TICKS));

    // Loop state codes
    localparam logic [STATE_W-1:0] LOOP_ENTER_A = 4'd2;
    localparam logic [STATE_W-1:0] LOOP_PRE_A   = 4'd3;
    localparam logic [STATE_W-1:0] LOOP_EXIT_A  = 4'd4;
    localparam logic [STATE_W-1:0] LOOP_ENTER_B = 4'd6;
    localparam logic [STATE_W-1:0] LOOP_PRE_B   = 4'd7;
    localparam logic [STATE_W-1:0] LOOP_EXIT_B  = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_YAW_PRE_EXIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_EXIT     = 1'd1;

    // One rate value per axis, x in slot 0.
    typedef logic [NUM_AXES-1:0][RATE_W-1:0] rate3_t;

    // Per-word side information carried down the pipeline.
    typedef struct packed {
        logic               calibrate;
        logic               cal_last;
        logic [STATE_W-1:0] loop_state;
    } item_ctl_t;

    // Control from the pipeline to the bias calibration unit.
    typedef struct packed {
        logic acc_en;
        logic finish;
    } cal_ctl_t;

endpackage

// ===== design/gyro_condition_and_yaw_track_unit.sv =====
// Top level of the gyro conditioning and yaw tracking block.
// Depends on gcy_pkg, gcy_hist_cell, gcy_avg, gcy_bias_cal and gcy_track.
//
// Usage:
//   Input words (three raw gyro rates, the calibrate flag and the loop state)
//   arrive on in_valid/in_stall; result words (three averaged rates, pitch and
//   yaw sums, new loop state) leave on out_valid/out_stall. A word moves at a
//   rising edge with valid high and stall low.
//   An accepted word passes the history sum, product and average registers
//   into the result word. Throughput is one word per cycle when neither a
//   receiver stall nor a calibration hold-off intervenes; the four-stage
//   pipeline keeps filling while the receiver stalls, and in_stall rises once
//   every stage holds a word or a calibration close is pending. The word that
//   closes a calibration window holds off input until the new biases land:
//   three stages to the calibration sums, then scaling by the reciprocal of
//   the window length. A receiver stall on that word lengthens the hold-off.
//   The two yaw limit registers are to be written through cfg_we/cfg_index/
//   cfg_data only while no word is in flight; the block does not enforce this.
//   Reset clears the history, sums and biases, loads the default limits and
//   sets the calibration count to one. No output word is valid after reset.

module gyro_condition_and_yaw_track_unit
    import gcy_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [LIM_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [RATE_W-1:0]  raw_rate_x,
    input  logic signed [RATE_W-1:0]  raw_rate_y,
    input  logic signed [RATE_W-1:0]  raw_rate_z,
    input  logic                      calibrate,
    input  logic [STATE_W-1:0]        loop_state_in,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [RATE_W-1:0]  rate_x_avg,
    output logic signed [RATE_W-1:0]  rate_y_avg,
    output logic signed [RATE_W-1:0]  rate_z_avg,
    output logic signed [PITCH_W-1:0] pitch_sum,
    output logic signed [YAW_W-1:0]   yaw_sum,
    output logic [STATE_W-1:0]        loop_state_out
);

    logic [LIM_W-1:0]  pre_limit_reg;
    logic [LIM_W-1:0]  exit_limit_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              out_valid_reg;
    logic              ready1;
    logic              ready2;
    logic              ready3;
    logic              out_free;
    logic              accept;
    logic              adv2;
    logic              adv3;
    logic              load_out;
    logic              pending_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_inc;
    logic              cal_last;
    item_ctl_t         ctl1_reg;
    item_ctl_t         ctl2_reg;
    item_ctl_t         ctl3_reg;
    rate3_t            raw3;
    rate3_t            h0;
    rate3_t            hist_tap [HIST_DEPTH+1];
    logic [HSUM_W-1:0] hsum_reg [NUM_AXES];
    rate3_t            avg3;
    rate3_t            bias3;
    rate3_t            out_avg3;
    cal_ctl_t          cal_ctl;
    logic              cal_done;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_limit_reg  <= LIM_W'(655360);
            exit_limit_reg <= LIM_W'(884736);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_YAW_PRE_EXIT: pre_limit_reg  <= cfg_data;
                REG_YAW_EXIT:     exit_limit_reg <= cfg_data;
                default:          pre_limit_reg  <= pre_limit_reg;
            endcase
        end
    end

    // Pipeline flow: each stage moves when the next one is empty or moving.
    assign out_free = !out_valid_reg || !out_stall;
    assign ready3   = !v3_reg || out_free;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1 || pending_reg;
    assign accept   = in_valid && !in_stall;
    assign adv2     = v1_reg && ready2;
    assign adv3     = v2_reg && ready3;
    assign load_out = v3_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                v1_reg <= 1'b1;
            end
            else if (adv2)
            begin
                v1_reg <= 1'b0;
            end
            if (adv2)
            begin
                v2_reg <= 1'b1;
            end
            else if (adv3)
            begin
                v2_reg <= 1'b0;
            end
            if (adv3)
            begin
                v3_reg <= 1'b1;
            end
            else if (load_out)
            begin
                v3_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Calibration window counting, and the hold-off until the new biases land.
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign cal_last = calibrate && (cnt_inc == CNT_W'(CALIB_TICKS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= CNT_W'(1);
            pending_reg <= 1'b0;
        end
        else
        begin
            if (accept && calibrate)
            begin
                cnt_reg <= cal_last ? '0 : cnt_inc;
            end
            if (accept && cal_last)
            begin
                pending_reg <= 1'b1;
            end
            else if (cal_done)
            begin
                pending_reg <= 1'b0;
            end
        end
    end

    // Word side information follows the data down the stages.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl1_reg <= '{calibrate: calibrate, cal_last: cal_last, loop_state: loop_state_in};
        end
        if (adv2)
        begin
            ctl2_reg <= ctl1_reg;
        end
        if (adv3)
        begin
            ctl3_reg <= ctl2_reg;
        end
    end

    // Bias removal, wrapping to the rate width.
    assign raw3[0] = raw_rate_x;
    assign raw3[1] = raw_rate_y;
    assign raw3[2] = raw_rate_z;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            h0[a] = raw3[a] - bias3[a];
        end
    end

    // History row: each cell passes its sample to the next on every accepted word.
    assign hist_tap[0] = h0;

    for (genvar i = 0; i < HIST_DEPTH; i++)
    begin : g_hist
        gcy_hist_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (accept),
            .d        (hist_tap[i]),
            .q        (hist_tap[i+1])
        );
    end

    // Running history sum: add the new sample, drop the one leaving the last cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                hsum_reg[a] <= '0;
            end
        end
        else if (accept)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                hsum_reg[a] <= hsum_reg[a]
                    + {{(HSUM_W-RATE_W){h0[a][RATE_W-1]}}, h0[a]}
                    - {{(HSUM_W-RATE_W){hist_tap[HIST_DEPTH][a][RATE_W-1]}},
                       hist_tap[HIST_DEPTH][a]};
            end
        end
    end

    // Averaging divide, one unit per axis.
    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_avg
        gcy_avg u_avg (
            .clk    (clk),
            .en_mul (adv2),
            .en_out (adv3),
            .sum    (hsum_reg[a]),
            .avg    (avg3[a])
        );
    end

    // Bias calibration.
    assign cal_ctl.acc_en = load_out && ctl3_reg.calibrate;
    assign cal_ctl.finish = load_out && ctl3_reg.cal_last;

    gcy_bias_cal u_bias_cal (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cal_ctl),
        .avg   (avg3),
        .bias  (bias3),
        .done  (cal_done)
    );

    // Pitch, yaw and loop state; the result word register.
    gcy_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load_out),
        .ctl        (ctl3_reg),
        .avg        (avg3),
        .pre_limit  (pre_limit_reg),
        .exit_limit (exit_limit_reg),
        .avg_out    (out_avg3),
        .pitch      (pitch_sum),
        .yaw        (yaw_sum),
        .state      (loop_state_out)
    );

    assign out_valid  = out_valid_reg;
    assign rate_x_avg = out_avg3[0];
    assign rate_y_avg = out_avg3[1];
    assign rate_z_avg = out_avg3[2];

    // The bias divide only finishes while input is held off for it.
    a_done_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cal_done |-> pending_reg)
        else $error("bias divide finished without a pending calibration");

    // Accepting the word that closes the window must hold off the next word.
    a_last_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cal_last) |=> pending_reg)
        else $error("calibration close did not hold off input");

    // A result word only appears when the last stage held a word.
    a_out_from_stage3: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v3_reg))
        else $error("result word appeared from an empty stage");

endmodule

// ===== design/gcy_hist_cell.sv =====
// One tap of the moving average history, holding one sample of each axis.
// Depends on gcy_pkg for the rate vector type.

module gcy_hist_cell
    import gcy_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift_en,
    input  rate3_t d,
    output rate3_t q
);

    rate3_t tap_reg;

    // Take the neighbor's sample whenever a new word enters the history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else if (shift_en)
        begin
            tap_reg <= d;
        end
    end

    assign q = tap_reg;

endmodule

// ===== design/gcy_avg.sv =====
// Two-stage divide of one axis's history sum by the history depth, truncating
// toward zero. Depends on gcy_pkg for widths and the reciprocal constant.

module gcy_avg
    import gcy_pkg::*;
(
    input  logic              clk,
    input  logic              en_mul,
    input  logic              en_out,
    input  logic [HSUM_W-1:0] sum,
    output logic [RATE_W-1:0] avg
);

    logic                  neg_reg;
    logic [AVG_PROD_W-1:0] prod_reg;
    logic [HSUM_W-1:0]     mag;
    logic [RATE_W-1:0]     quot;
    logic [RATE_W-1:0]     avg_reg;

    // Magnitude of the sum, then multiply by the reciprocal of the depth.
    assign mag = sum[HSUM_W-1] ? (~sum + HSUM_W'(1)) : sum;

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            neg_reg  <= sum[HSUM_W-1];
            prod_reg <= AVG_PROD_W'(mag) * AVG_PROD_W'(AVG_MUL);
        end
    end

    // Drop the fraction and put the sign back.
    assign quot = prod_reg[AVG_SHIFT +: RATE_W];

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            avg_reg <= neg_reg ? (~quot + RATE_W'(1)) : quot;
        end
    end

    assign avg = avg_reg;

endmodule

// ===== design/gcy_bias_cal.sv =====
// Calibration sums and the reciprocal multiply that turns them into new biases.
// Depends on gcy_pkg for widths, the calibration length and the control struct.

module gcy_bias_cal
    import gcy_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cal_ctl_t ctl,
    input  rate3_t   avg,
    output rate3_t   bias,
    output logic     done
);

    logic [CSUM_W-1:0]     csum_reg  [NUM_AXES];
    logic [CSUM_W-1:0]     csum_next [NUM_AXES];
    logic [CSUM_W-1:0]     mag       [NUM_AXES];
    logic [CSUM_W-1:0]     mag_reg   [NUM_AXES];
    logic                  neg_reg   [NUM_AXES];
    logic [CAL_PROD_W-1:0] prod_reg  [NUM_AXES];
    logic [RATE_W-1:0]     quot      [NUM_AXES];
    rate3_t                bias_reg;
    rate3_t                bias_next;
    logic                  mul_busy_reg;
    logic                  fix_busy_reg;

    // Running sums, sum magnitudes and the signed quotient of each axis.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            csum_next[a] = csum_reg[a]
                         + {{(CSUM_W-RATE_W){avg[a][RATE_W-1]}}, avg[a]};
            mag[a] = csum_next[a][CSUM_W-1] ? (~csum_next[a] + CSUM_W'(1)) : csum_next[a];
            quot[a] = prod_reg[a][CAL_SHIFT +: RATE_W];
            bias_next[a] = neg_reg[a] ? (~quot[a] + RATE_W'(1)) : quot[a];
        end
    end

    assign done = fix_busy_reg;

    // Sums, divide sequencing and the bias registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                csum_reg[a] <= '0;
            end
            bias_reg     <= '0;
            mul_busy_reg <= 1'b0;
            fix_busy_reg <= 1'b0;
        end
        else
        begin
            if (ctl.acc_en)
            begin
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    csum_reg[a] <= csum_next[a];
                end
            end
            mul_busy_reg <= ctl.finish;
            fix_busy_reg <= mul_busy_reg;
            if (fix_busy_reg)
            begin
                bias_reg <= bias_next;
            end
        end
    end

    // Divider datapath: capture the magnitude, then multiply by the reciprocal.
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (ctl.finish)
            begin
                mag_reg[a] <= mag[a];
                neg_reg[a] <= csum_next[a][CSUM_W-1];
            end
            if (mul_busy_reg)
            begin
                prod_reg[a] <= CAL_PROD_W'(mag_reg[a]) * CAL_PROD_W'(CAL_MUL);
            end
        end
    end

    assign bias = bias_reg;

endmodule

// ===== design/gcy_track.sv =====
// Pitch and yaw sums with the loop state update; its registers are the result word.
// Depends on gcy_pkg for widths, loop state codes and the item control struct.

module gcy_track
    import gcy_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  item_ctl_t          ctl,
    input  rate3_t             avg,
    input  logic [LIM_W-1:0]   pre_limit,
    input  logic [LIM_W-1:0]   exit_limit,
    output rate3_t             avg_out,
    output logic [PITCH_W-1:0] pitch,
    output logic [YAW_W-1:0]   yaw,
    output logic [STATE_W-1:0] state
);

    localparam int YW1 = YAW_W + 1;

    logic [PITCH_W-1:0] pitch_reg;
    logic [PITCH_W-1:0] pitch_next;
    logic [PITCH_W:0]   pitch_wide;
    logic [YAW_W-1:0]   yaw_reg;
    logic [YAW_W-1:0]   yaw_next;
    logic [YAW_W:0]     yaw_wide;
    logic [YAW_W-1:0]   yaw_sat;
    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    rate3_t             avg_reg;
    logic               tracking;
    logic signed [YW1-1:0] y_e;
    logic signed [YW1-1:0] p_e;
    logic signed [YW1-1:0] e_e;
    logic signed [YW1-1:0] np_e;
    logic signed [YW1-1:0] ne_e;

    // Saturating pitch sum of the y rate.
    always_comb
    begin
        pitch_wide = {pitch_reg[PITCH_W-1], pitch_reg}
                   + {{(PITCH_W+1-RATE_W){avg[1][RATE_W-1]}}, avg[1]};
        if (pitch_wide[PITCH_W] != pitch_wide[PITCH_W-1])
        begin
            pitch_next = pitch_wide[PITCH_W] ? {1'b1, {(PITCH_W-1){1'b0}}}
                                             : {1'b0, {(PITCH_W-1){1'b1}}};
        end
        else
        begin
            pitch_next = pitch_wide[PITCH_W-1:0];
        end
    end

    // Saturating yaw sum of the z rate and the threshold checks.
    always_comb
    begin
        tracking = (ctl.loop_state == LOOP_ENTER_A) || (ctl.loop_state == LOOP_PRE_A)
                || (ctl.loop_state == LOOP_ENTER_B) || (ctl.loop_state == LOOP_PRE_B);
        yaw_wide = {yaw_reg[YAW_W-1], yaw_reg}
                 + {{(YAW_W+1-RATE_W){avg[2][RATE_W-1]}}, avg[2]};
        if (yaw_wide[YAW_W] != yaw_wide[YAW_W-1])
        begin
            yaw_sat = yaw_wide[YAW_W] ? {1'b1, {(YAW_W-1){1'b0}}}
                                      : {1'b0, {(YAW_W-1){1'b1}}};
        end
        else
        begin
            yaw_sat = yaw_wide[YAW_W-1:0];
        end
        y_e  = $signed({yaw_sat[YAW_W-1], yaw_sat});
        p_e  = $signed({{(YW1-LIM_W){1'b0}}, pre_limit});
        e_e  = $signed({{(YW1-LIM_W){1'b0}}, exit_limit});
        np_e = -p_e;
        ne_e = -e_e;

        yaw_next   = yaw_reg;
        state_next = ctl.loop_state;
        if (tracking)
        begin
            yaw_next = yaw_sat;
            priority if ((y_e > p_e) && (y_e < e_e))
            begin
                state_next = LOOP_PRE_A;
            end
            else if ((y_e < np_e) && (y_e > ne_e))
            begin
                state_next = LOOP_PRE_B;
            end
            else if (y_e > e_e)
            begin
                state_next = LOOP_EXIT_A;
                yaw_next   = '0;
            end
            else if (y_e < ne_e)
            begin
                state_next = LOOP_EXIT_B;
                yaw_next   = '0;
            end
            else
            begin
                state_next = ctl.loop_state;
            end
        end
    end

    // Accumulators double as the result word's sum fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= '0;
            yaw_reg   <= '0;
        end
        else if (load)
        begin
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            avg_reg   <= avg;
            state_reg <= state_next;
        end
    end

    assign avg_out = avg_reg;
    assign pitch   = pitch_reg;
    assign yaw     = yaw_reg;
    assign state   = state_reg;

endmodule
